/* design/r3fs_pkg.sv */
package r3fs_pkg;

  localparam int RING_DEPTH_DEF = 2048;

  localparam int CNT_W  = 32;
  localparam int TYPE_W = 12;
  localparam int LEN_W  = 10;
  localparam int POS_W  = 11;
  localparam int CRC_W  = 24;

  localparam logic [7:0]  SYNC_BYTE   = 8'hD3;
  localparam logic [7:0]  RSV_MASK    = 8'hFC;
  localparam logic [7:0]  LEN_HI_MASK = 8'h03;
  localparam logic [24:0] CRC_POLY    = 25'h1864CFB;

  typedef logic [2:0] ev_t;
  localparam ev_t EV_NONE     = 3'd0;
  localparam ev_t EV_DROP     = 3'd1;
  localparam ev_t EV_FAIL_RSV = 3'd2;
  localparam ev_t EV_FAIL_CRC = 3'd3;
  localparam ev_t EV_ACCEPT   = 3'd4;

  // candidate frame, starting at the oldest held byte
  typedef struct packed {
    logic [POS_W-1:0] pos;      // bytes of the candidate fed so far
    logic [LEN_W-1:0] len;
    logic [1:0]       len_hi;
    logic             rsv_bad;
    logic [CRC_W-1:0] crc;
    logic             bad;      // trailer mismatch seen
    logic [7:0]       pl0;
    logic [3:0]       pl1_hi;
  } cand_t;

  typedef struct packed {
    ev_t               ev;
    cand_t             nxt;
    logic [TYPE_W-1:0] msg_type;
    logic              type_ok;
    logic [LEN_W-1:0]  length;
  } feed_res_t;

  function automatic logic [CRC_W-1:0] crc24q_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] d);
    logic [24:0] c;
    c = {1'b0, crc ^ {d, 16'h0000}};
    for (int i = 0; i < 8; i++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[CRC_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + CNT_W'(1);
  endfunction

endpackage

/* design/r3fs_feed.sv */
module r3fs_feed (
  input  logic [7:0]         d,
  input  r3fs_pkg::cand_t    cand,
  output r3fs_pkg::feed_res_t res
);

  logic [r3fs_pkg::POS_W-1:0] lim;
  logic [r3fs_pkg::POS_W-1:0] tsel;
  logic [7:0]                 exp_byte;
  logic [7:0]                 hi_bits;
  logic                       bad_n;

  // first trailer byte sits at len+3
  assign lim     = {1'b0, cand.len} + r3fs_pkg::POS_W'(3);
  assign tsel    = cand.pos - lim;
  assign hi_bits = d & r3fs_pkg::LEN_HI_MASK;

  always_comb begin
    case (tsel[1:0])
      2'd0:    exp_byte = cand.crc[23:16];
      2'd1:    exp_byte = cand.crc[15:8];
      default: exp_byte = cand.crc[7:0];
    endcase
  end

  assign bad_n = cand.bad | (d != exp_byte);

  always_comb begin
    res          = '0;
    res.ev       = r3fs_pkg::EV_NONE;
    res.nxt      = cand;
    res.type_ok  = (cand.len >= r3fs_pkg::LEN_W'(2));
    res.msg_type = res.type_ok ? {cand.pl0, cand.pl1_hi} : '0;
    res.length   = cand.len;

    if (cand.pos == '0) begin
      if (d == r3fs_pkg::SYNC_BYTE) begin
        res.nxt.pos = r3fs_pkg::POS_W'(1);
        res.nxt.crc = r3fs_pkg::crc24q_byte('0, d);
        res.nxt.bad = 1'b0;
      end else begin
        res.ev = r3fs_pkg::EV_DROP;
      end
    end else if (cand.pos == r3fs_pkg::POS_W'(1)) begin
      res.nxt.len_hi  = hi_bits[1:0];
      res.nxt.rsv_bad = (d & r3fs_pkg::RSV_MASK) != 8'h00;
      res.nxt.crc     = r3fs_pkg::crc24q_byte(cand.crc, d);
      res.nxt.pos     = r3fs_pkg::POS_W'(2);
    end else if (cand.pos == r3fs_pkg::POS_W'(2)) begin
      // reserved bits are judged only once three bytes are held
      if (cand.rsv_bad) begin
        res.ev = r3fs_pkg::EV_FAIL_RSV;
      end else begin
        res.nxt.len = {cand.len_hi, d};
        res.nxt.crc = r3fs_pkg::crc24q_byte(cand.crc, d);
        res.nxt.pos = r3fs_pkg::POS_W'(3);
      end
    end else if (cand.pos < lim) begin
      res.nxt.crc = r3fs_pkg::crc24q_byte(cand.crc, d);
      if (cand.pos == r3fs_pkg::POS_W'(3)) begin
        res.nxt.pl0 = d;
      end
      if (cand.pos == r3fs_pkg::POS_W'(4)) begin
        res.nxt.pl1_hi = d[7:4];
      end
      res.nxt.pos = cand.pos + r3fs_pkg::POS_W'(1);
    end else begin
      res.nxt.bad = bad_n;
      res.nxt.pos = cand.pos + r3fs_pkg::POS_W'(1);
      if (cand.pos == lim + r3fs_pkg::POS_W'(2)) begin
        res.ev = bad_n ? r3fs_pkg::EV_FAIL_CRC : r3fs_pkg::EV_ACCEPT;
      end
    end

    if (res.ev != r3fs_pkg::EV_NONE) begin
      res.nxt.pos = '0;
    end
  end

endmodule

/* design/rtcm3_frame_sync_crc_check_top.sv */
// Result timing: a beat's result is registered and valid in the cycle after the byte is
//   taken; a rejection adds a rescan of the held bytes, plus a further rescan for each
//   further rejection, as the single ring read port refeeds one byte a cycle.
// Throughput: one byte per cycle while no rejection occurs and results are taken.
// Reset (rst_n low, synchronous): counters, latest-frame fields, ring pointers
//   and handshake state clear; ring contents stay undefined and need no pass.
module rtcm3_frame_sync_crc_check_top #(
  parameter int RING_DEPTH = r3fs_pkg::RING_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] stream_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] frames_total, [63:32] crc_fail_total, [95:64] discard_total,
  // [96] new_frame, [97] new_crc_failure, [109:98] last_message_type,
  // [110] last_type_valid, [120:111] last_payload_length,
  // [131:121] pending_bytes, [135:132] zero
  output logic [135:0] out_tdata
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  logic [7:0] ring [0:RING_DEPTH-1];
  logic [7:0] rdata_r;

  logic                          st_r, st_nxt;
  logic [AW-1:0]                 start_r, start_nxt;
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic [AW-1:0]                 ip_r, ip_nxt;
  logic [AW-1:0]                 da_r, da_nxt;
  logic                          dv_r, dv_nxt;
  r3fs_pkg::cand_t               cand_r, cand_nxt;
  logic [r3fs_pkg::CNT_W-1:0]    frames_r, frames_nxt;
  logic [r3fs_pkg::CNT_W-1:0]    crcfail_r, crcfail_nxt;
  logic [r3fs_pkg::CNT_W-1:0]    discard_r, discard_nxt;
  logic [r3fs_pkg::TYPE_W-1:0]   ltype_r, ltype_nxt;
  logic                          ltype_ok_r, ltype_ok_nxt;
  logic [r3fs_pkg::LEN_W-1:0]    llen_r, llen_nxt;
  logic                          frame_flag_r, frame_flag_nxt;
  logic                          fail_flag_r, fail_flag_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          idle;
  logic                          accept;
  logic                          feed_go;
  logic [7:0]                    feed_byte;
  logic [AW-1:0]                 feed_pos;
  logic                          fail_now;
  logic                          rd_en;
  r3fs_pkg::feed_res_t           res;

  assign idle      = (st_r == ST_IDLE);
  assign in_tready = idle && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  // new bytes feed straight from the port; rescans feed from the ring
  assign feed_go   = idle ? accept : dv_r;
  assign feed_byte = idle ? in_tdata : rdata_r;
  assign feed_pos  = idle ? wp_r : da_r;

  r3fs_feed u_feed (
    .d    (feed_byte),
    .cand (cand_r),
    .res  (res)
  );

  assign fail_now = feed_go &&
                    (res.ev == r3fs_pkg::EV_FAIL_RSV || res.ev == r3fs_pkg::EV_FAIL_CRC);
  assign rd_en    = !idle && !fail_now && (ip_r != wp_r);

  always_ff @(posedge clk) begin
    if (accept) begin
      ring[wp_r] <= in_tdata;
    end
    if (rd_en) begin
      rdata_r <= ring[ip_r];
    end
  end

  always_comb begin
    st_nxt         = st_r;
    start_nxt      = start_r;
    wp_nxt         = wp_r;
    ip_nxt         = ip_r;
    da_nxt         = da_r;
    dv_nxt         = dv_r;
    cand_nxt       = cand_r;
    frames_nxt     = frames_r;
    crcfail_nxt    = crcfail_r;
    discard_nxt    = discard_r;
    ltype_nxt      = ltype_r;
    ltype_ok_nxt   = ltype_ok_r;
    llen_nxt       = llen_r;
    frame_flag_nxt = frame_flag_r;
    fail_flag_nxt  = fail_flag_r;
    out_valid_nxt  = out_valid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      wp_nxt         = ptr_inc(wp_r);
      frame_flag_nxt = 1'b0;
      fail_flag_nxt  = 1'b0;
    end

    if (feed_go) begin
      cand_nxt = res.nxt;
      case (res.ev)
        r3fs_pkg::EV_DROP: begin
          discard_nxt = r3fs_pkg::sat_inc(discard_r);
          start_nxt   = ptr_inc(feed_pos);
        end
        r3fs_pkg::EV_FAIL_RSV: begin
          discard_nxt = r3fs_pkg::sat_inc(discard_r);
          start_nxt   = ptr_inc(start_r);
        end
        r3fs_pkg::EV_FAIL_CRC: begin
          discard_nxt   = r3fs_pkg::sat_inc(discard_r);
          crcfail_nxt   = r3fs_pkg::sat_inc(crcfail_r);
          fail_flag_nxt = 1'b1;
          start_nxt     = ptr_inc(start_r);
        end
        r3fs_pkg::EV_ACCEPT: begin
          frames_nxt     = r3fs_pkg::sat_inc(frames_r);
          ltype_nxt      = res.msg_type;
          ltype_ok_nxt   = res.type_ok;
          llen_nxt       = res.length;
          frame_flag_nxt = 1'b1;
          start_nxt      = ptr_inc(feed_pos);
        end
        default: begin
        end
      endcase
    end

    if (fail_now) begin
      // drop the preamble, refeed from the byte after it; in-flight read is stale
      st_nxt = ST_SCAN;
      ip_nxt = ptr_inc(start_r);
      dv_nxt = 1'b0;
    end else if (!idle) begin
      if (ip_r != wp_r) begin
        ip_nxt = ptr_inc(ip_r);
        da_nxt = ip_r;
        dv_nxt = 1'b1;
      end else begin
        dv_nxt = 1'b0;
        if (!dv_r) begin
          st_nxt        = ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
    end else if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      start_r      <= '0;
      wp_r         <= '0;
      ip_r         <= '0;
      dv_r         <= 1'b0;
      cand_r       <= '0;
      frames_r     <= '0;
      crcfail_r    <= '0;
      discard_r    <= '0;
      ltype_r      <= '0;
      ltype_ok_r   <= 1'b0;
      llen_r       <= '0;
      frame_flag_r <= 1'b0;
      fail_flag_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      start_r      <= start_nxt;
      wp_r         <= wp_nxt;
      ip_r         <= ip_nxt;
      dv_r         <= dv_nxt;
      cand_r       <= cand_nxt;
      frames_r     <= frames_nxt;
      crcfail_r    <= crcfail_nxt;
      discard_r    <= discard_nxt;
      ltype_r      <= ltype_nxt;
      ltype_ok_r   <= ltype_ok_nxt;
      llen_r       <= llen_nxt;
      frame_flag_r <= frame_flag_nxt;
      fail_flag_r  <= fail_flag_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    da_r <= da_nxt;
  end

  // when idle every held byte belongs to the candidate, so its offset is the fill
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, cand_r.pos, llen_r, ltype_ok_r, ltype_r,
                       fail_flag_r, frame_flag_r, discard_r, crcfail_r, frames_r};

  a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> !dv_r)
    else $error("ring read in flight while idle");

  a_scan_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) |-> !in_tready && !out_valid_r)
    else $error("input taken or result shown during rescan");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(frames_r) && $stable(discard_r) &&
                                     $stable(cand_r.pos))
    else $error("result changed while waiting");

  a_fail_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    fail_now |=> (st_r == ST_SCAN) && !dv_r && (ip_r == start_r))
    else $error("rejection did not restart the rescan");

  a_frames_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> frames_r >= $past(frames_r))
    else $error("frame count went backwards");

endmodule
